>>> sv/multichannel_sample_frame_deframer_core_defines.svh
// ----------------------------------------------------------------------------
// Deframer assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_SAMPLE_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define MULTICHANNEL_SAMPLE_FRAME_DEFRAMER_CORE_DEFINES_SVH

// Implication property sampled on the rising clock, disabled during reset.
`define MFD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define MFD_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> sv/mfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer package
// Widths, defaults and shared types of the sample frame deframer.
// ----------------------------------------------------------------------------
package mfd_pkg;

   localparam int BYTE_W       = 8;
   localparam int SAMPLE_W     = 24;
   localparam int CHAN_W       = 4;
   localparam int CHANNELS_DEF = 16;

   typedef logic [BYTE_W-1:0]          byte_type;
   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [CHAN_W-1:0]          chan_type;

endpackage

>>> sv/mfd_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample store
// One-write, one-read synchronous memory holding the samples of a frame.
// ----------------------------------------------------------------------------
module mfd_store
   import mfd_pkg::*;
#(
   parameter int DEPTH = CHANNELS_DEF,
   parameter int AW    = 4
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  sample_type    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output sample_type    rd_data
);

   sample_type mem [DEPTH];
   sample_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/mfd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame parser
// Byte-wise header hunt, sample assembly, checksum and trailer handling.
// ----------------------------------------------------------------------------
module mfd_parser
   import mfd_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF,
   parameter int AW       = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          byte_valid,
   input  byte_type      byte_data,
   input  logic          byte_ready,
   output logic          wr_en,
   output logic [AW-1:0] wr_addr,
   output sample_type    wr_data,
   output logic          start
);

   localparam logic [2:0] PH_HUNT_FIRST  = 3'd0;
   localparam logic [2:0] PH_HUNT_SECOND = 3'd1;
   localparam logic [2:0] PH_PAYLOAD     = 3'd2;
   localparam logic [2:0] PH_CHECK       = 3'd3;
   localparam logic [2:0] PH_TRAILER     = 3'd4;

   localparam byte_type      HDR_FIRST  = 8'hBB;
   localparam byte_type      HDR_SECOND = 8'hAA;
   localparam logic [AW-1:0] IDX_LAST   = AW'(CHANNELS - 1);

   localparam logic [1:0] POS_HIGH = 2'd0;
   localparam logic [1:0] POS_MID  = 2'd1;
   localparam logic [1:0] POS_LOW  = 2'd2;

   logic [2:0]    phase_ff, phase_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [1:0]    pos_ff, pos_in;
   byte_type      sum_ff, sum_in;
   logic [15:0]   partial_ff, partial_in;
   logic          take;

   assign take = byte_valid && byte_ready;

   always_comb begin
      phase_in   = phase_ff;
      idx_in     = idx_ff;
      pos_in     = pos_ff;
      sum_in     = sum_ff;
      partial_in = partial_ff;
      wr_en      = 1'b0;
      wr_addr    = idx_ff;
      wr_data    = {partial_ff, byte_data};
      start      = 1'b0;
      if (take) begin
         unique case (phase_ff)
            PH_HUNT_SECOND: begin
               if (byte_data == HDR_SECOND) begin
                  phase_in   = PH_PAYLOAD;
                  idx_in     = '0;
                  pos_in     = POS_HIGH;
                  sum_in     = '0;
                  partial_in = '0;
               end else if (byte_data == HDR_FIRST) begin
                  phase_in = PH_HUNT_SECOND;
               end else begin
                  phase_in = PH_HUNT_FIRST;
               end
            end
            PH_PAYLOAD: begin
               sum_in = sum_ff + byte_data;
               case (pos_ff)
                  POS_HIGH: begin
                     partial_in = {byte_data, 8'h00};
                     pos_in     = POS_MID;
                  end
                  POS_MID: begin
                     partial_in = {partial_ff[15:8], byte_data};
                     pos_in     = POS_LOW;
                  end
                  default: begin
                     wr_en  = 1'b1;
                     pos_in = POS_HIGH;
                     idx_in = idx_ff + 1'b1;
                     if (idx_ff == IDX_LAST) begin
                        phase_in = PH_CHECK;
                     end
                  end
               endcase
            end
            PH_CHECK: begin
               // The checksum byte is the bitwise inverse of the payload sum.
               start    = (byte_data == ~sum_ff);
               phase_in = PH_TRAILER;
            end
            PH_TRAILER: begin
               phase_in = PH_HUNT_FIRST;
            end
            default: begin
               phase_in = (byte_data == HDR_FIRST) ? PH_HUNT_SECOND : PH_HUNT_FIRST;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT_FIRST;
         idx_ff     <= '0;
         pos_ff     <= POS_HIGH;
         sum_ff     <= '0;
         partial_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         idx_ff     <= idx_in;
         pos_ff     <= pos_in;
         sum_ff     <= sum_in;
         partial_ff <= partial_in;
      end
   end

endmodule

>>> sv/mfd_emit.sv
`timescale 1ns / 1ps
`include "multichannel_sample_frame_deframer_core_defines.svh"
// ----------------------------------------------------------------------------
// Sample emitter
// Reads a verified frame from the store and sends one sample per transaction.
// ----------------------------------------------------------------------------
module mfd_emit
   import mfd_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF,
   parameter int AW       = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          idle,
   output logic          rd_en,
   output logic [AW-1:0] rd_addr,
   input  sample_type    rd_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output chan_type      rsp_channel,
   output sample_type    rsp_sample,
   output logic          rsp_last
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;
   localparam logic [1:0] ST_SHOW  = 2'd2;

   localparam logic [AW-1:0] IDX_LAST = AW'(CHANNELS - 1);

   logic [1:0]    state_ff, state_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic          valid_ff, valid_in;
   sample_type    sample_ff, sample_in;

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      valid_in  = valid_ff;
      sample_in = sample_ff;
      rd_en     = 1'b0;
      rd_addr   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rd_en    = 1'b1;
               rd_addr  = '0;
               idx_in   = '0;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            sample_in = rd_data;
            valid_in  = 1'b1;
            state_in  = ST_SHOW;
         end
         ST_SHOW: begin
            if (rsp_ready) begin
               valid_in = 1'b0;
               if (idx_ff == IDX_LAST) begin
                  state_in = ST_IDLE;
               end else begin
                  // Fetch the next channel as soon as this one is taken.
                  rd_en    = 1'b1;
                  rd_addr  = idx_ff + 1'b1;
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            valid_in = 1'b0;
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
   end

   assign idle        = (state_ff == ST_IDLE);
   assign rsp_valid   = valid_ff;
   assign rsp_sample  = sample_ff;
   assign rsp_channel = CHAN_W'(idx_ff);
   assign rsp_last    = (idx_ff == IDX_LAST);

   `MFD_ASSERT(a_start_when_idle, clock, reset, start |-> state_ff == ST_IDLE, "frame start while busy")
   `MFD_ASSERT(a_fetch_then_show, clock, reset, state_ff == ST_FETCH |=> (state_ff == ST_SHOW && valid_ff), "fetched sample not presented")
   `MFD_ASSERT(a_last_ends_burst, clock, reset, (valid_ff && rsp_ready && rsp_last) |=> (state_ff == ST_IDLE && !valid_ff), "burst continues after last sample")
   `MFD_NEVER(a_valid_only_in_show, clock, reset, valid_ff && state_ff != ST_SHOW, "output valid outside show state")

endmodule

>>> sv/multichannel_sample_frame_deframer_core.sv
`timescale 1ns / 1ps
// Frame start: a matching checksum byte starts the emitter, which reads the first sample
// from the store in its fetch state and then offers it registered in its show state.
// Throughput: one byte per cycle while parsing; a verified frame is sent as a burst
// of CHANNELS samples, each read from the store and then held on the output until the
// consumer takes it, and no byte is accepted until the burst ends.
// Reset (synchronous) returns the parser to the header hunt and empties the output;
// the sample store is not cleared, since every entry is written before it is read.
// ----------------------------------------------------------------------------
// Multichannel sample frame deframer
// Finds 0xBB 0xAA framed payloads of 24-bit samples, checks the inverted-sum
// checksum and emits the 24-bit signed samples of each verified frame.
// ----------------------------------------------------------------------------
module multichannel_sample_frame_deframer_core
   import mfd_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  byte_type   req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output chan_type   rsp_channel,
   output sample_type rsp_sample,
   output logic       rsp_last
);

   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   sample_type    wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   sample_type    rd_data;
   logic          start;
   logic          emit_idle;

   assign req_ready = emit_idle;

   mfd_parser #(
      .CHANNELS (CHANNELS),
      .AW       (AW)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_valid),
      .byte_data  (req_rx_byte),
      .byte_ready (req_ready),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .start      (start)
   );

   mfd_store #(
      .DEPTH (CHANNELS),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mfd_emit #(
      .CHANNELS (CHANNELS),
      .AW       (AW)
   ) u_emit (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .idle        (emit_idle),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_channel (rsp_channel),
      .rsp_sample  (rsp_sample),
      .rsp_last    (rsp_last)
   );

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample frame deframer testbench
// Feeds byte streams of well-formed, corrupted and broken frames mixed with
// noise into the deframer, predicts the verified samples of each frame and
// checks every sample transaction, under random stalls on both sides and a long consumer stall.
// ----------------------------------------------------------------------------
module testbench
   import mfd_pkg::*;
();

   localparam int       ITEMS         = 430;
   localparam int       NO_ACCEPT_MAX = 3000;
   localparam int       HOLD_CYCLES   = 300;
   localparam int       DRAIN_CYCLES  = 20;
   localparam byte_type HEADER_FIRST  = 8'hBB;
   localparam byte_type HEADER_SECOND = 8'hAA;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MOST_NEG = 24'h800000;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MOST_POS = 24'h7FFFFF;
   localparam logic [SAMPLE_W-1:0] SAMPLE_ZERO     = 24'h000000;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MINUS_1  = 24'hFFFFFF;

   typedef enum logic [2:0] {
      HUNT_FIRST, HUNT_SECOND, PAYLOAD, CHECKSUM, TRAILER
   } parse_phase_type;

   typedef enum int {CKS_GOOD, CKS_HIGH_BIT, CKS_ONE_BIT, CKS_RANDOM_BYTE} cks_fault_type;

   typedef struct {
      chan_type   channel;
      sample_type sample;
      logic       last;
   } frame_sample_type;

   // Tracks the parser state byte by byte and queues the samples of each
   // frame whose checksum matches.
   class frame_scoreboard;
      parse_phase_type     phase;
      int unsigned         byte_count;
      logic [15:0]         partial;
      byte_type            running_sum;
      logic [SAMPLE_W-1:0] sample_store [CHANNELS_DEF];
      frame_sample_type    expected_samples [$];
      int                  mismatches;
      int                  received;

      function new();
         phase       = HUNT_FIRST;
         byte_count  = 0;
         partial     = '0;
         running_sum = '0;
         mismatches  = 0;
         received    = 0;
      endfunction

      function void note_byte(byte_type b);
         frame_sample_type s;
         case (phase)
            HUNT_SECOND: begin
               if (b == HEADER_SECOND) begin
                  phase       = PAYLOAD;
                  byte_count  = 0;
                  running_sum = '0;
                  partial     = '0;
               end else begin
                  phase = (b == HEADER_FIRST) ? HUNT_SECOND : HUNT_FIRST;
               end
            end
            PAYLOAD: begin
               running_sum = running_sum + b;
               case (byte_count % 3)
                  0: partial = {b, 8'h00};
                  1: partial[7:0] = b;
                  default: sample_store[byte_count / 3] = {partial, b};
               endcase
               byte_count++;
               if (byte_count >= 3 * CHANNELS_DEF) phase = CHECKSUM;
            end
            CHECKSUM: begin
               if (b == ~running_sum) begin
                  for (int k = 0; k < CHANNELS_DEF; k++) begin
                     s.channel = chan_type'(k);
                     s.sample  = sample_store[k];
                     s.last    = (k == CHANNELS_DEF - 1);
                     expected_samples.push_back(s);
                  end
               end
               phase = TRAILER;
            end
            TRAILER: phase = HUNT_FIRST;
            default: phase = (b == HEADER_FIRST) ? HUNT_SECOND : HUNT_FIRST;
         endcase
      endfunction

      task report(string msg);
         if (mismatches < 40) $display("MISMATCH: %s", msg);
         mismatches++;
      endtask

      task check_sample(chan_type ch, sample_type smp, logic last);
         frame_sample_type e;
         received++;
         if (expected_samples.size() == 0) begin
            report($sformatf("unexpected sample ch %0d value %h last %b", ch, smp, last));
         end else begin
            e = expected_samples.pop_front();
            if (ch !== e.channel || smp !== e.sample || last !== e.last)
               report($sformatf("sample %0d: got ch %0d %h last %b, expected ch %0d %h last %b",
                                received, ch, smp, last, e.channel, e.sample, e.last));
         end
      endtask

      function int pending();
         return expected_samples.size();
      endfunction
   endclass

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   byte_type   req_rx_byte = '0;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   chan_type   rsp_channel;
   sample_type rsp_sample;
   logic       rsp_last;

   frame_scoreboard sb = new();
   int  items_sent     = 0;
   int  send_idle_pct  = 26;
   int  recv_idle_pct  = 86;
   bit  hold_request   = 1'b0;
   int  no_accept_count = 0;

   multichannel_sample_frame_deframer_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_channel (rsp_channel),
      .rsp_sample  (rsp_sample),
      .rsp_last    (rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Idle rates swap after the first third of the stream and stop after the second.
   task send_byte(byte_type b);
      if (items_sent < ITEMS / 3) begin
         send_idle_pct = 26;
         recv_idle_pct = 86;
      end else if (items_sent < 2 * ITEMS / 3) begin
         send_idle_pct = 86;
         recv_idle_pct = 26;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      sb.note_byte(b);
      items_sent++;
   endtask

   function logic [SAMPLE_W-1:0] pick_sample(bit extremes, int k);
      if (extremes) begin
         case (k % 4)
            0: return SAMPLE_MOST_NEG;
            1: return SAMPLE_MOST_POS;
            2: return SAMPLE_ZERO;
            default: return SAMPLE_MINUS_1;
         endcase
      end
      case ($urandom_range(7))
         0: return SAMPLE_MOST_NEG;
         1: return SAMPLE_MOST_POS;
         2: return SAMPLE_ZERO;
         3: return SAMPLE_MINUS_1;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task send_frame(bit extremes, cks_fault_type fault);
      logic [SAMPLE_W-1:0] v;
      byte_type            sum;
      byte_type            cks;
      sum = '0;
      send_byte(HEADER_FIRST);
      send_byte(HEADER_SECOND);
      for (int k = 0; k < CHANNELS_DEF; k++) begin
         v = pick_sample(extremes, k);
         send_byte(v[23:16]);
         send_byte(v[15:8]);
         send_byte(v[7:0]);
         sum = sum + v[23:16] + v[15:8] + v[7:0];
      end
      cks = ~sum;
      case (fault)
         CKS_HIGH_BIT:    cks = cks ^ 8'h80;
         CKS_ONE_BIT:     cks = cks ^ (8'h01 << $urandom_range(7));
         CKS_RANDOM_BYTE: cks = byte_type'($urandom_range(255));
         default: ;
      endcase
      send_byte(cks);
      send_byte(byte_type'($urandom_range(255)));
   endtask

   // Stray bytes between frames, biased toward header bytes.
   task send_noise();
      int n;
      n = $urandom_range(4);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(3))
            0: send_byte(HEADER_FIRST);
            1: send_byte(HEADER_SECOND);
            default: send_byte(byte_type'($urandom_range(255)));
         endcase
      end
   endtask

   initial begin
      int  r;
      bit  hold_done;
      hold_done = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Header hunt corner cases: lone second byte, broken headers and
      // repeated first bytes.
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(HEADER_SECOND);
      send_byte(HEADER_FIRST);
      send_byte(8'h00);
      send_byte(HEADER_FIRST);
      send_byte(8'h55);
      send_byte(HEADER_FIRST);
      send_byte(HEADER_FIRST);
      send_byte(8'h12);
      // A doubled first header byte still leads into a frame.
      send_byte(HEADER_FIRST);
      send_frame(1'b1, CKS_GOOD);
      send_frame(1'b1, CKS_HIGH_BIT);
      send_frame(1'b0, CKS_GOOD);

      while (items_sent < ITEMS) begin
         if (!hold_done && items_sent >= 2 * ITEMS / 3) begin
            // Stall the consumer over a verified frame, then let it drain.
            hold_done    = 1'b1;
            hold_request = 1'b1;
            send_frame(1'b0, CKS_GOOD);
            req_valid <= 1'b0;
            while (sb.pending() != 0) @(posedge clock);
         end else begin
            send_noise();
            r = $urandom_range(9);
            if (r < 6)      send_frame(1'b0, CKS_GOOD);
            else if (r < 8) send_frame(1'b0, CKS_ONE_BIT);
            else            send_frame(1'b0, CKS_RANDOM_BYTE);
         end
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d expected samples never arrived", sb.pending()));
      if (sb.mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check_sample(rsp_channel, rsp_sample, rsp_last);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         no_accept_count <= 0;
      end else if (no_accept_count >= NO_ACCEPT_MAX) begin
         $display("TIMEOUT: no transaction for %0d cycles", NO_ACCEPT_MAX);
         $display("== FAIL ==");
         $finish;
      end else begin
         no_accept_count <= no_accept_count + 1;
      end
   end

endmodule

>>> sim.f
+incdir+sv
sv/mfd_pkg.sv
sv/mfd_store.sv
sv/mfd_parser.sv
sv/mfd_emit.sv
sv/multichannel_sample_frame_deframer_core.sv
sim/testbench.sv
